@@ hw/rtl/tslm_pkg.sv @@
// Shared constants, codes and control structs for the tolerant sorted-list merge.
// No dependencies; imported by every module of the block.
package tslm_pkg;

  localparam int LIST_DEPTH = 1024;
  localparam int VALUE_BITS = 32;
  localparam int TOL_W      = 31;
  localparam int ADDR_W     = $clog2(LIST_DEPTH);
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int CMP_W      = ((VALUE_BITS > TOL_W) ? VALUE_BITS : TOL_W) + 1;

  typedef enum logic [1:0] {
    MODE_POINT = 2'd0,
    MODE_LAST  = 2'd1,
    MODE_END   = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    OP_KEEP   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_DROP   = 2'd3
  } op_e;

  typedef struct packed {
    logic accept;     // latch the request, clear the run counter
    logic advance;    // step past one stored point above the band
    logic emit_head;  // send the remove run that precedes the edit
    logic edit;       // send keep, insert or drop and update the lists
    logic finish;     // send the tail remove if any, swap banks
  } cmd_t;

  typedef struct packed {
    logic scan_more;
    logic run_nz;
    logic out_free;
    logic tail_pend;
    logic mode_last;
  } sts_t;

endpackage

@@ hw/rtl/tolerant_sorted_list_merge.sv @@
// Top level of the tolerant sorted-list merge: controller plus datapath.
// Depends on tslm_pkg, tslm_ctrl and tslm_dp.
//
//   Channel   Direction  Handshake                 Payload
//   in        input      in_valid_i / in_ready_o   mode_i, point_value_i
//   out       output     out_valid_o / out_ready_i edit_op_o, edit_index_o, run_length_o,
//                                                  edit_value_o, last_of_run_o
//   cfg       input      cfg_we_i (no wait)        cfg_wdata_i (match tolerance)
//
// A point is accepted, then the scan steps past each stored point removed ahead of it and
// compares against the stored point it faces; the loop is the single registered read port
// of the list memory, one stored point per cycle. Reset clears pointers, counts and the
// bank select; list contents are not cleared. A stalled output holds the controller at its
// next result.
module tolerant_sorted_list_merge import tslm_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [TOL_W-1:0]             cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   mode_i,
  input  logic signed [VALUE_BITS-1:0] point_value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   edit_op_o,
  output logic [CNT_W-1:0]             edit_index_o,
  output logic [CNT_W-1:0]             run_length_o,
  output logic signed [VALUE_BITS-1:0] edit_value_o,
  output logic                         last_of_run_o
);

  cmd_t cmd;
  sts_t sts;

  // sequence each request: scan past stored points, emit up to three results
  tslm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .mode_i     (mode_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // hold the two list banks, pointers and the result register
  tslm_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .mode_i        (mode_i),
    .point_value_i (point_value_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .edit_op_o     (edit_op_o),
    .edit_index_o  (edit_index_o),
    .run_length_o  (run_length_o),
    .edit_value_o  (edit_value_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

@@ hw/rtl/tslm_ctrl.sv @@
// Controller state machine of the tolerant sorted-list merge.
// Depends on tslm_pkg for the mode codes and the command/status structs.
module tslm_ctrl import tslm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] mode_i,
  output logic       in_ready_o,
  input  sts_t       sts_i,
  output cmd_t       cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_EDIT = 4'b0100,
    ST_TAIL = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          case (mode_e'(mode_i))
            MODE_POINT, MODE_LAST: state_d = ST_SCAN;
            MODE_END:              state_d = ST_TAIL;
            default:               state_d = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (sts_i.scan_more) begin
          cmd_o.advance = 1'b1;
        end else if (sts_i.out_free) begin
          if (sts_i.run_nz) begin
            cmd_o.emit_head = 1'b1;
            state_d = ST_EDIT;
          end else begin
            cmd_o.edit = 1'b1;
            state_d = sts_i.mode_last ? ST_TAIL : ST_IDLE;
          end
        end
      end
      ST_EDIT: begin
        if (sts_i.out_free) begin
          cmd_o.edit = 1'b1;
          state_d = sts_i.mode_last ? ST_TAIL : ST_IDLE;
        end
      end
      ST_TAIL: begin
        if (!sts_i.tail_pend || sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hw/rtl/tslm_dp.sv @@
// Datapath of the tolerant sorted-list merge: list memory, pointers, band compare,
// and the result register. Depends on tslm_pkg.
module tslm_dp import tslm_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [TOL_W-1:0]             cfg_wdata_i,
  input  logic [1:0]                   mode_i,
  input  logic signed [VALUE_BITS-1:0] point_value_i,
  input  cmd_t                         cmd_i,
  output sts_t                         sts_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   edit_op_o,
  output logic [CNT_W-1:0]             edit_index_o,
  output logic [CNT_W-1:0]             run_length_o,
  output logic signed [VALUE_BITS-1:0] edit_value_o,
  output logic                         last_of_run_o
);

  // both banks in one array; the bank bit is the top address bit
  logic [VALUE_BITS-1:0] mem_q [2*LIST_DEPTH];
  logic [VALUE_BITS-1:0] rdata_q;

  logic [TOL_W-1:0]             tol_q;
  logic signed [VALUE_BITS-1:0] x_q;
  logic                         mode_last_q;
  logic [CNT_W-1:0]             run_q, run_d;
  logic [CNT_W-1:0]             r_q, r_d;
  logic [CNT_W-1:0]             w_q, w_d;
  logic [CNT_W-1:0]             stored_q, stored_d;
  logic                         bank_q, bank_d;

  logic                         out_valid_q;
  logic [1:0]                   op_q;
  logic [CNT_W-1:0]             idx_q, len_q;
  logic signed [VALUE_BITS-1:0] val_q;
  logic                         last_q;

  logic signed [CMP_W-1:0] x_ext, old_ext, tol_ext, diff;
  logic old_avail, above, below, keep, full;
  logic [CNT_W-1:0] r_edit;
  logic edit_last, out_free, load;

  // band compare on one difference
  assign x_ext   = CMP_W'(x_q);
  assign old_ext = CMP_W'(signed'(rdata_q));
  assign tol_ext = signed'(CMP_W'(tol_q));
  assign diff    = x_ext - old_ext;
  assign above   = diff > tol_ext;
  assign below   = diff < -tol_ext;

  assign old_avail = r_q < stored_q;
  assign keep      = old_avail && !below;
  assign full      = w_q == CNT_W'(LIST_DEPTH);
  assign r_edit    = r_q + CNT_W'(keep && !full);
  assign edit_last = !mode_last_q || !(r_edit < stored_q);
  assign out_free  = !out_valid_q || out_ready_i;

  assign sts_o.scan_more = old_avail && above;
  assign sts_o.run_nz    = run_q != '0;
  assign sts_o.out_free  = out_free;
  assign sts_o.tail_pend = old_avail;
  assign sts_o.mode_last = mode_last_q;

  always_comb begin
    run_d    = run_q;
    r_d      = r_q;
    w_d      = w_q;
    stored_d = stored_q;
    bank_d   = bank_q;
    if (cmd_i.accept) begin
      run_d = '0;
    end
    if (cmd_i.advance) begin
      r_d   = r_q + CNT_W'(1);
      run_d = run_q + CNT_W'(1);
    end
    if (cmd_i.edit && !full) begin
      r_d = r_edit;
      w_d = w_q + CNT_W'(1);
    end
    if (cmd_i.finish) begin
      bank_d   = ~bank_q;
      stored_d = w_q;
      r_d      = '0;
      w_d      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q       <= '0;
      mode_last_q <= 1'b0;
      run_q       <= '0;
      r_q         <= '0;
      w_q         <= '0;
      stored_q    <= '0;
      bank_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        tol_q <= cfg_wdata_i;
      end
      if (cmd_i.accept) begin
        mode_last_q <= mode_e'(mode_i) == MODE_LAST;
      end
      run_q    <= run_d;
      r_q      <= r_d;
      w_q      <= w_d;
      stored_q <= stored_d;
      bank_q   <= bank_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // read the old bank at the next read pointer so rdata_q tracks r_q
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[{bank_d, r_d[ADDR_W-1:0]}];
    if (cmd_i.edit && !full) begin
      mem_q[{~bank_q, w_q[ADDR_W-1:0]}] <= keep ? rdata_q : x_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      x_q <= point_value_i;
    end
  end

  assign load = cmd_i.emit_head || cmd_i.edit || (cmd_i.finish && old_avail);

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_head) begin
      op_q   <= OP_REMOVE;
      idx_q  <= w_q;
      len_q  <= run_q;
      val_q  <= '0;
      last_q <= 1'b0;
    end else if (cmd_i.edit) begin
      op_q   <= full ? OP_DROP : (keep ? OP_KEEP : OP_INSERT);
      idx_q  <= w_q;
      len_q  <= full ? '0 : CNT_W'(1);
      val_q  <= (keep && !full) ? signed'(rdata_q) : x_q;
      last_q <= edit_last;
    end else if (cmd_i.finish && old_avail) begin
      op_q   <= OP_REMOVE;
      idx_q  <= w_q;
      len_q  <= stored_q - r_q;
      val_q  <= '0;
      last_q <= 1'b1;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign edit_op_o     = op_q;
  assign edit_index_o  = idx_q;
  assign run_length_o  = len_q;
  assign edit_value_o  = val_q;
  assign last_of_run_o = last_q;

endmodule

@@ hw/rtl/tslm_checker.sv @@
// Port-level checks for the tolerant sorted-list merge, bound to the top level.
// Depends on tslm_pkg.
module tslm_checker import tslm_pkg::*; (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [1:0]                   edit_op_o,
  input logic [CNT_W-1:0]             edit_index_o,
  input logic [CNT_W-1:0]             run_length_o,
  input logic signed [VALUE_BITS-1:0] edit_value_o,
  input logic                         last_of_run_o
);

  a_ready_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i |-> !$isunknown(in_ready_o))
    else $error("input ready unknown while a request is offered");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(edit_op_o)
      && $stable(edit_index_o) && $stable(run_length_o) && $stable(edit_value_o))
    else $error("result changed while stalled");

  a_single_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (edit_op_o == OP_KEEP || edit_op_o == OP_INSERT)
      |-> run_length_o == CNT_W'(1) && edit_index_o < CNT_W'(LIST_DEPTH))
    else $error("keep or insert with bad length or index");

  a_remove_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && edit_op_o == OP_REMOVE |-> run_length_o != '0 && edit_value_o == '0)
    else $error("remove run empty or carries a value");

  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && edit_op_o == OP_DROP
      |-> run_length_o == '0 && edit_index_o == CNT_W'(LIST_DEPTH) && last_of_run_o == 1'b1
        || run_length_o == '0 && edit_index_o == CNT_W'(LIST_DEPTH))
    else $error("drop while merged list not full");

endmodule

bind tolerant_sorted_list_merge tslm_checker u_tslm_checker (.*);

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the tolerant sorted-list merge (edit script generator).
// Depends on tslm_pkg and tolerant_sorted_list_merge; predicts every edit from its own
// copy of the two list banks and the pointers, and checks each output request in order.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tslm_pkg::*;

  // Run limits. Settle covers the ignored requests and an empty set end, which give no
  // edit but still occupy the block.
  localparam int LIMIT_CYCLES  = 600000;
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES   = 400;
  localparam longint VAL_MAX   = (longint'(1) <<< (VALUE_BITS - 1)) - 1;
  localparam longint VAL_MIN   = -(longint'(1) <<< (VALUE_BITS - 1));

  typedef struct {
    op_e                         op;
    logic [CNT_W-1:0]            ix;
    logic [CNT_W-1:0]            count;
    logic signed [VALUE_BITS-1:0] val;
    logic                        last;
  } edit_t;

  // DUT ports; every input starts at a known value
  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          cfg_we_i      = 1'b0;
  logic [TOL_W-1:0]              cfg_wdata_i   = '0;
  logic                          in_valid_i    = 1'b0;
  logic                          in_ready_o;
  logic [1:0]                    mode_i        = 2'b00;
  logic signed [VALUE_BITS-1:0]  point_value_i = '0;
  logic                          out_valid_o;
  logic                          out_ready_i   = 1'b0;
  logic [1:0]                    edit_op_o;
  logic [CNT_W-1:0]              edit_index_o;
  logic [CNT_W-1:0]              run_length_o;
  logic signed [VALUE_BITS-1:0]  edit_value_o;
  logic                          last_of_run_o;

  // Merge state as the block should hold it
  logic signed [VALUE_BITS-1:0]  list_mem [2][LIST_DEPTH];
  bit                            held_bank;
  int unsigned                   held_count;
  int unsigned                   scan_pos;
  int unsigned                   merge_pos;
  logic [TOL_W-1:0]              tol_model;

  edit_t pending_edits[$];
  int    errors;
  int    cycles;
  int    idle_pct;
  int    stall_pct;

  // Long receiver hold-off: the test flips hold_toggle, the counter process does the rest
  bit    hold_toggle;
  bit    hold_seen;
  int    hold_left;

  tolerant_sorted_list_merge dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .point_value_i(point_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .edit_op_o    (edit_op_o),
    .edit_index_o (edit_index_o),
    .run_length_o (run_length_o),
    .edit_value_o (edit_value_o),
    .last_of_run_o(last_of_run_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------------

  // new point lies above the tolerance band of the stored point
  function automatic bit over_band(longint x, longint held);
    return x > held && (x - held) > longint'(tol_model);
  endfunction

  // new point lies below the tolerance band of the stored point
  function automatic bit under_band(longint x, longint held);
    return held > x && (held - x) > longint'(tol_model);
  endfunction

  function automatic edit_t make_edit(op_e op, int unsigned ix, int unsigned count,
                                      longint val);
    edit_t e;
    e.op    = op;
    e.ix    = CNT_W'(ix);
    e.count = CNT_W'(count);
    e.val   = VALUE_BITS'(val);
    e.last  = 1'b0;
    return e;
  endfunction

  // Work out the edits one request causes and advance the merge state.
  // The edited list is merged[0..merge_pos) followed by stored[scan_pos..held_count).
  task automatic predict_edits(mode_e m, logic signed [VALUE_BITS-1:0] pv);
    edit_t       eds[$];
    longint      x;
    longint      held;
    int unsigned rd;
    int unsigned wr;
    int unsigned first;
    x  = pv;
    rd = scan_pos;
    wr = merge_pos;
    if (m == MODE_NONE) return;
    if (m == MODE_POINT || m == MODE_LAST) begin
      // skip every stored point lying above the band; report them as one run
      first = rd;
      while (rd < held_count && over_band(x, list_mem[held_bank][rd])) rd++;
      if (rd > first) eds.push_back(make_edit(OP_REMOVE, wr, rd - first, 0));
      if (wr >= LIST_DEPTH) begin
        // merged list full: drop the point, the stored point it faces stays
        eds.push_back(make_edit(OP_DROP, wr, 0, x));
      end else if (rd < held_count && !under_band(x, list_mem[held_bank][rd])) begin
        held = list_mem[held_bank][rd];
        list_mem[!held_bank][wr] = VALUE_BITS'(held);
        eds.push_back(make_edit(OP_KEEP, wr, 1, held));
        rd++;
        wr++;
      end else begin
        list_mem[!held_bank][wr] = pv;
        eds.push_back(make_edit(OP_INSERT, wr, 1, x));
        wr++;
      end
    end
    if (m == MODE_LAST || m == MODE_END) begin
      // close the set: drop the stored tail, swap banks
      if (rd < held_count) eds.push_back(make_edit(OP_REMOVE, wr, held_count - rd, 0));
      held_bank  = !held_bank;
      held_count = wr;
      scan_pos   = 0;
      merge_pos  = 0;
    end else begin
      scan_pos  = rd;
      merge_pos = wr;
    end
    if (eds.size() > 0) eds[eds.size() - 1].last = 1'b1;
    foreach (eds[k]) pending_edits.push_back(eds[k]);
  endtask

  // ---------------------------------------------------------------------------------
  // Checking and receiver side
  // ---------------------------------------------------------------------------------

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    errors++;
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // Compare each accepted edit with the oldest expectation, then pick the next ready.
  always @(posedge clk_i) begin
    edit_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_edits.size() == 0) begin
        report_mismatch($sformatf("unexpected edit op %0d index %0d", edit_op_o,
                                  edit_index_o));
      end else begin
        want = pending_edits.pop_front();
        check_field("edit_op", edit_op_o, want.op);
        check_field("edit_index", edit_index_o, want.ix);
        check_field("run_length", run_length_o, want.count);
        check_field("edit_value", edit_value_o, want.val);
        check_field("last_of_run", last_of_run_o, want.last);
      end
    end
    out_ready_i <= (hold_left == 0) && ($urandom_range(0, 99) >= stall_pct);
  end

  // Count down the long hold-off in its own process
  always @(posedge clk_i) begin
    if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Watchdog: a hang or a lost edit ends up here
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------------

  // Offer one request, idling first at random; return at the edge that accepts it.
  // Valid stays high into the next request when no idle cycle falls in between.
  task automatic send_point(mode_e m, logic signed [VALUE_BITS-1:0] pv);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    mode_i        <= m;
    point_value_i <= pv;
    predict_edits(m, pv);
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Hold the sender until every expected edit is back, then let the block settle
  task automatic wait_edits_done();
    in_valid_i <= 1'b0;
    while (pending_edits.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write the tolerance only while the block is idle
  task automatic write_tolerance(logic [TOL_W-1:0] tol);
    wait_edits_done();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= tol;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    tol_model    = tol;
  endtask

  function automatic logic signed [VALUE_BITS-1:0] clamp_value(longint v);
    if (v > VAL_MAX) return VALUE_BITS'(VAL_MAX);
    if (v < VAL_MIN) return VALUE_BITS'(VAL_MIN);
    return VALUE_BITS'(v);
  endfunction

  // Move a value exactly onto, just past, or somewhere inside the tolerance band
  function automatic longint nudge(longint v);
    longint span;
    longint off;
    span = (tol_model > 'h20000) ? 'h20000 : longint'(tol_model);
    case ($urandom_range(0, 3))
      0:       off = 0;
      1:       off = longint'($urandom_range(0, 32'(span * 2))) - span;
      2:       off = longint'(tol_model) + 1;
      default: off = longint'(tol_model);
    endcase
    if ($urandom_range(0, 1)) off = -off;
    return v + off;
  endfunction

  // Build one new set from the stored list: some stored points vanish, some come back
  // within or just outside the band, fresh ones get inserted. Mostly ascending.
  task automatic run_random_set(ref int sent);
    longint base[$];
    longint pts[$];
    int     extra;
    int     c;
    bit     close_on_point;
    mode_e  m;
    for (int k = 0; k < held_count; k++) base.push_back(list_mem[held_bank][k]);
    foreach (base[k]) begin
      c = $urandom_range(0, 9);
      if (c < 3) continue;
      if (c < 8) pts.push_back(nudge(base[k]));
      else pts.push_back($signed($urandom));
    end
    extra = $urandom_range(base.size() == 0 ? 1 : 0, 4);
    repeat (extra) begin
      if (base.size() > 0 && $urandom_range(0, 1))
        pts.push_back(nudge(base[$urandom_range(0, base.size() - 1)]));
      else
        pts.push_back($signed($urandom));
    end
    // leave a few sets out of order
    if ($urandom_range(0, 9) != 0) pts.sort();
    while (pts.size() > 20) void'(pts.pop_back());
    close_on_point = pts.size() > 0 && $urandom_range(0, 1);
    foreach (pts[k]) begin
      // sprinkle ignored requests through the set
      if ($urandom_range(0, 99) < 8) send_point(MODE_NONE, $urandom);
      m = (close_on_point && k == pts.size() - 1) ? MODE_LAST : MODE_POINT;
      send_point(m, clamp_value(pts[k]));
      sent++;
    end
    if (!close_on_point) begin
      send_point(MODE_END, $urandom);
      sent++;
    end
  endtask

  // ---------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------

  // Extremes, keep, insert and remove edits, band edges, ignored requests, empty set end
  task automatic test_directed();
    idle_pct  = 0;
    stall_pct = 0;
    // tolerance still at its reset value of zero
    send_point(MODE_END,   '0);              // empty list: banks swap, no edit
    send_point(MODE_NONE,  32'sh7FFFFFFF);   // ignored
    send_point(MODE_POINT, 32'sh80000000);
    send_point(MODE_POINT, 32'shFFFF0000);
    send_point(MODE_POINT, 32'sh00000000);
    send_point(MODE_POINT, 32'sh00010000);
    send_point(MODE_LAST,  32'sh7FFFFFFF);
    // second set: keep, remove run then insert, keep with tail removal
    send_point(MODE_POINT, 32'sh80000000);
    send_point(MODE_POINT, 32'sh00008000);
    send_point(MODE_NONE,  32'sh00000000);
    send_point(MODE_LAST,  32'sh00010000);
    // widest band: full-range distances still decide remove versus keep
    write_tolerance(31'h7FFFFFFF);
    send_point(MODE_POINT, 32'sh7FFFFFFF);
    send_point(MODE_POINT, 32'sh80000000);
    send_point(MODE_END,   32'sh12345678);
    // half a unit: points exactly on the band edge still match
    write_tolerance(31'h00008000);
    send_point(MODE_POINT, 32'sh00000000);
    send_point(MODE_POINT, 32'sh80000001);
    send_point(MODE_END,   32'sh00000000);   // nothing left to remove
  endtask

  // Fill the merged list, then push points past capacity
  task automatic test_overflow();
    write_tolerance('0);
    idle_pct  = 0;
    stall_pct = 0;
    send_point(MODE_POINT, 32'sh03E80000);
    send_point(MODE_POINT, 32'sh07D00000);
    send_point(MODE_LAST,  32'sh0BB80000);
    for (int i = 0; i < LIST_DEPTH; i++) send_point(MODE_POINT, VALUE_BITS'(i * 256));
    send_point(MODE_POINT, 32'sh05DC0000);   // remove run, then drop
    send_point(MODE_POINT, 32'sh07D00000);   // would match, but no room: drop
    send_point(MODE_LAST,  32'sh13880000);   // remove run, drop, nothing left
    send_point(MODE_END,   32'sh00000000);   // remove the whole full list
  endtask

  task automatic test_random_sets(int target, int idle, int stall, logic [TOL_W-1:0] tol);
    int sent;
    write_tolerance(tol);
    idle_pct  = idle;
    stall_pct = stall;
    sent      = 0;
    while (sent < target) run_random_set(sent);
  endtask

  // Block the receiver for a long stretch while requests keep coming, so the block
  // fills up and stalls its input; then pause until every edit is back.
  task automatic test_backpressure();
    longint pts[$];
    write_tolerance(31'h00010000);
    idle_pct  = 0;
    stall_pct = 0;
    repeat (24) pts.push_back($signed($urandom));
    pts.sort();
    hold_toggle <= ~hold_toggle;
    foreach (pts[k]) send_point(k == pts.size() - 1 ? MODE_LAST : MODE_POINT,
                                VALUE_BITS'(pts[k]));
    wait_edits_done();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_overflow();
    test_random_sets(45, 0,  0,  31'h00010000);
    test_random_sets(45, 78, 0,  '0);
    test_random_sets(45, 0,  78, 31'h7FFFFFFF);
    test_random_sets(45, 29, 29, 31'($urandom_range(0, 32'h0003FFFF)));
    test_backpressure();

    wait_edits_done();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/tslm_pkg.sv
hw/rtl/tslm_ctrl.sv
hw/rtl/tslm_dp.sv
hw/rtl/tolerant_sorted_list_merge.sv
hw/rtl/tslm_checker.sv
tb/sv/tb_top.sv
